// File: rtl/fee_pkg.sv
// Shared types and codes for the two-page flash record store.
// Used by fee_ctrl, fee_dp and flash_eeprom_emulator; depends on nothing.
package fee_pkg;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [2:0] RES_OK        = 3'd0;
  localparam logic [2:0] RES_NO_PAGE   = 3'd1;
  localparam logic [2:0] RES_NOT_FOUND = 3'd2;
  localparam logic [2:0] RES_NO_SLOT   = 3'd3;
  localparam logic [2:0] RES_UNKNOWN   = 3'd4;

  localparam logic [15:0] PG_ERASED  = 16'hFFFF;
  localparam logic [15:0] PG_RECEIVE = 16'hEEEE;
  localparam logic [15:0] PG_VALID   = 16'h0000;
  localparam logic [15:0] FREE_TAG   = 16'hFFFF;

  typedef struct packed {
    logic       load_in;
    logic       init_apply;
    logic       idx_fill;
    logic       idx_dec;
    logic       slot_rd;
    logic       wr;
    logic       cp_start;
    logic       sidx_clr;
    logic       sidx_inc;
    logic       seen_rd;
    logic       seen_add;
    logic       copy;
    logic       cp_end;
    logic       res_load;
    logic [2:0] res_code;
    logic       res_use_rd;
    logic       out_load;
  } fee_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       init_bad;
    logic       act_ok;
    logic       act_full;
    logic       act_empty;
    logic       tag_free;
    logic       rd_match;
    logic       rd_tag_free;
    logic       seen_match;
    logic       seen_last;
    logic       seen_empty;
    logic       seen_full;
    logic       to_full;
    logic       idx_zero;
  } fee_stat_t;

endpackage

// File: rtl/fee_ctrl.sv
// Controller state machine for the flash record store.
// Depends on fee_pkg; drives fee_dp through fee_cmd_t.
module fee_ctrl
  import fee_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  fee_stat_t st,
  output fee_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD_ADDR, S_RD_CHK, S_CP_RD, S_CP_TAG, S_CP_SEEN_RD,
    S_CP_SEEN_CHK, S_CP_NEW, S_CP_NEXT, S_CP_END, S_WR_TRY, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt    = S_FINISH;
        cmd.res_load = 1'b1;
        cmd.res_code = RES_OK;
        case (st.cmd)
          CMD_INIT: begin
            cmd.init_apply = 1'b1;
            cmd.res_code   = st.init_bad ? RES_UNKNOWN : RES_OK;
          end
          CMD_READ: begin
            if (!st.act_ok) begin
              cmd.res_code = RES_NO_PAGE;
            end else if (st.tag_free || st.act_empty) begin
              cmd.res_code = RES_NOT_FOUND;
            end else begin
              cmd.res_load = 1'b0;
              cmd.idx_fill = 1'b1;
              state_nxt    = S_RD_ADDR;
            end
          end
          CMD_WRITE: begin
            if (!st.act_ok) begin
              cmd.res_code = RES_NO_PAGE;
            end else if (!st.act_full) begin
              cmd.wr = 1'b1;
            end else begin
              cmd.res_load = 1'b0;
              cmd.cp_start = 1'b1;
              state_nxt    = S_CP_RD;
            end
          end
          default: begin
            cmd.res_code = RES_OK;
          end
        endcase
      end
      S_RD_ADDR: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_RD_CHK;
      end
      S_RD_CHK: begin
        if (st.rd_match) begin
          cmd.res_load   = 1'b1;
          cmd.res_code   = RES_OK;
          cmd.res_use_rd = 1'b1;
          state_nxt      = S_FINISH;
        end else if (st.idx_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_code = RES_NOT_FOUND;
          state_nxt    = S_FINISH;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_RD_ADDR;
        end
      end
      S_CP_RD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_CP_TAG;
      end
      S_CP_TAG: begin
        if (st.rd_tag_free) begin
          state_nxt = S_CP_NEXT;
        end else if (st.seen_empty) begin
          state_nxt = S_CP_NEW;
        end else begin
          cmd.sidx_clr = 1'b1;
          state_nxt    = S_CP_SEEN_RD;
        end
      end
      S_CP_SEEN_RD: begin
        cmd.seen_rd = 1'b1;
        state_nxt   = S_CP_SEEN_CHK;
      end
      S_CP_SEEN_CHK: begin
        if (st.seen_match) begin
          state_nxt = S_CP_NEXT;
        end else if (st.seen_last) begin
          state_nxt = S_CP_NEW;
        end else begin
          cmd.sidx_inc = 1'b1;
          state_nxt    = S_CP_SEEN_RD;
        end
      end
      S_CP_NEW: begin
        if (st.seen_full) begin
          state_nxt = S_CP_NEXT;
        end else if (st.to_full) begin
          cmd.seen_add = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = RES_NO_SLOT;
          state_nxt    = S_FINISH;
        end else begin
          cmd.seen_add = 1'b1;
          cmd.copy     = 1'b1;
          state_nxt    = S_CP_NEXT;
        end
      end
      S_CP_NEXT: begin
        if (st.idx_zero) begin
          state_nxt = S_CP_END;
        end else begin
          cmd.idx_dec = 1'b1;
          state_nxt   = S_CP_RD;
        end
      end
      S_CP_END: begin
        cmd.cp_end = 1'b1;
        state_nxt  = S_WR_TRY;
      end
      S_WR_TRY: begin
        cmd.res_load = 1'b1;
        if (st.act_full) begin
          cmd.res_code = RES_NO_SLOT;
        end else begin
          cmd.res_code = RES_OK;
          cmd.wr       = 1'b1;
        end
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/fee_dp.sv
// Datapath for the flash record store: page status words, fill counts,
// slot memory, dedup tag memory, scan counters and result registers. Uses fee_pkg.
module fee_dp
  import fee_pkg::*;
#(
  parameter int PAGE_BYTES    = 2048,
  parameter int RECORD_BYTES  = 8,
  parameter int DEDUP_ENTRIES = 68
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_virtual_address,
  input  logic [63:0] in_write_data,
  output logic [2:0]  out_status,
  output logic [63:0] out_read_data,
  input  fee_cmd_t    cmd,
  output fee_stat_t   st
);

  localparam int SLOTS = (PAGE_BYTES - 2) / (RECORD_BYTES + 2);
  localparam int DEPTH = 2 * SLOTS;
  localparam int RW    = 8 * RECORD_BYTES;
  localparam int SW    = $clog2(SLOTS + 1);
  localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEDUP_ENTRIES + 1);
  localparam int NW    = (DEDUP_ENTRIES > 1) ? $clog2(DEDUP_ENTRIES) : 1;

  logic [1:0]        cmd_r;
  logic [15:0]       tag_r;
  logic [63:0]       data_r;
  logic [1:0][15:0]  pstat_r, pstat_nxt;
  logic [1:0][SW-1:0] fill_r, fill_nxt;
  logic              page_r;
  logic [IW-1:0]     idx_r;
  logic [CW-1:0]     seen_n_r, sidx_r;
  logic [RW+15:0]    slot_mem [DEPTH];
  logic [RW+15:0]    slot_q;
  logic [15:0]       seen_mem [DEDUP_ENTRIES];
  logic [15:0]       seen_q;
  logic [2:0]        res_st_r;
  logic [63:0]       res_rd_r;
  logic [2:0]        out_status_r;
  logic [63:0]       out_read_data_r;

  logic              act_pg, to_pg;
  logic [1:0][15:0]  ps_init;
  logic [1:0]        clr_init;
  logic              init_bad;
  logic [15:0]       q_tag;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [RW+15:0]    wr_data;

  function automatic logic [AW-1:0] slot_addr(logic pg, logic [IW-1:0] i);
    logic [AW-1:0] base;
    base = pg ? AW'(SLOTS) : '0;
    return base + AW'(i);
  endfunction

  assign act_pg = (pstat_r[0] != PG_VALID);
  assign to_pg  = !page_r;
  assign q_tag  = slot_q[RW+15:RW];

  always_comb begin
    ps_init  = pstat_r;
    clr_init = 2'b00;
    init_bad = 1'b0;
    case (pstat_r[0])
      PG_ERASED: begin
        if (pstat_r[1] == PG_VALID) begin
          clr_init[0] = 1'b1;
        end else if (pstat_r[1] == PG_RECEIVE) begin
          clr_init[0] = 1'b1;
          ps_init[1]  = PG_VALID;
        end else begin
          clr_init = 2'b11;
          ps_init  = {PG_ERASED, PG_VALID};
        end
      end
      PG_RECEIVE: begin
        if (pstat_r[1] == PG_VALID || pstat_r[1] == PG_ERASED) begin
          clr_init[1] = 1'b1;
          ps_init     = {PG_ERASED, PG_VALID};
        end else begin
          clr_init = 2'b11;
          ps_init  = {PG_ERASED, PG_VALID};
        end
      end
      PG_VALID: begin
        if (pstat_r[1] == PG_VALID) begin
          clr_init = 2'b11;
          ps_init  = {PG_ERASED, PG_VALID};
        end else if (pstat_r[1] == PG_ERASED) begin
          clr_init[1] = 1'b1;
        end else begin
          clr_init[0] = 1'b1;
          ps_init     = {PG_VALID, PG_ERASED};
        end
      end
      default: begin
        init_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    pstat_nxt = pstat_r;
    fill_nxt  = fill_r;
    if (cmd.init_apply && !init_bad) begin
      pstat_nxt = ps_init;
      if (clr_init[0]) fill_nxt[0] = '0;
      if (clr_init[1]) fill_nxt[1] = '0;
    end
    if (cmd.wr && tag_r != FREE_TAG) begin
      fill_nxt[act_pg] = fill_r[act_pg] + SW'(1);
    end
    if (cmd.cp_start) begin
      pstat_nxt[!act_pg] = PG_RECEIVE;
    end
    if (cmd.copy) begin
      fill_nxt[to_pg] = fill_r[to_pg] + SW'(1);
    end
    if (cmd.cp_end) begin
      pstat_nxt[to_pg]  = PG_VALID;
      pstat_nxt[page_r] = PG_ERASED;
      fill_nxt[page_r]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pstat_r  <= {PG_ERASED, PG_ERASED};
      fill_r   <= '0;
      page_r   <= 1'b0;
      idx_r    <= '0;
      seen_n_r <= '0;
      sidx_r   <= '0;
    end else begin
      pstat_r <= pstat_nxt;
      fill_r  <= fill_nxt;
      if (cmd.idx_fill) begin
        page_r <= act_pg;
        idx_r  <= IW'(fill_r[act_pg] - SW'(1));
      end else if (cmd.cp_start) begin
        page_r <= act_pg;
        idx_r  <= IW'(SLOTS - 1);
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - IW'(1);
      end
      if (cmd.cp_start) begin
        seen_n_r <= '0;
      end else if (cmd.seen_add) begin
        seen_n_r <= seen_n_r + CW'(1);
      end
      if (cmd.sidx_clr) begin
        sidx_r <= '0;
      end else if (cmd.sidx_inc) begin
        sidx_r <= sidx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r  <= in_command;
      tag_r  <= in_virtual_address;
      data_r <= in_write_data;
    end
    if (cmd.res_load) begin
      res_st_r <= cmd.res_code;
      res_rd_r <= cmd.res_use_rd ? 64'(slot_q[RW-1:0]) : '0;
    end
    if (cmd.out_load) begin
      out_status_r    <= res_st_r;
      out_read_data_r <= res_rd_r;
    end
  end

  assign rd_addr = slot_addr(page_r, idx_r);
  assign wr_en   = cmd.wr || cmd.copy;
  assign wr_addr = cmd.copy ? slot_addr(to_pg, fill_r[to_pg][IW-1:0])
                            : slot_addr(act_pg, fill_r[act_pg][IW-1:0]);
  assign wr_data = cmd.copy ? slot_q : {tag_r, data_r[RW-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (cmd.slot_rd) begin
      slot_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seen_add) begin
      seen_mem[seen_n_r[NW-1:0]] <= q_tag;
    end
    if (cmd.seen_rd) begin
      seen_q <= seen_mem[sidx_r[NW-1:0]];
    end
  end

  assign out_status    = out_status_r;
  assign out_read_data = out_read_data_r;

  always_comb begin
    st             = '0;
    st.cmd         = cmd_r;
    st.init_bad    = init_bad;
    st.act_ok      = (pstat_r[0] == PG_VALID && pstat_r[1] == PG_ERASED) ||
                     (pstat_r[0] == PG_ERASED && pstat_r[1] == PG_VALID);
    st.act_full    = (fill_r[act_pg] >= SW'(SLOTS));
    st.act_empty   = (fill_r[act_pg] == '0);
    st.tag_free    = (tag_r == FREE_TAG);
    st.rd_match    = (q_tag == tag_r);
    st.rd_tag_free = (q_tag == FREE_TAG);
    st.seen_match  = (seen_q == q_tag);
    st.seen_last   = (sidx_r + CW'(1) == seen_n_r);
    st.seen_empty  = (seen_n_r == '0);
    st.seen_full   = (seen_n_r == CW'(DEDUP_ENTRIES));
    st.to_full     = (fill_r[to_pg] >= SW'(SLOTS));
    st.idx_zero    = (idx_r == '0);
  end

`ifndef SYNTHESIS
  a_fill0_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= SW'(SLOTS)) else $error("page 0 fill count past slot count");
  a_fill1_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[1] <= SW'(SLOTS)) else $error("page 1 fill count past slot count");
  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_n_r <= CW'(DEDUP_ENTRIES)) else $error("dedup count past table size");
  a_copy_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.copy |-> (fill_r[to_pg] < SW'(SLOTS) && pstat_r[to_pg] == PG_RECEIVE))
    else $error("copy into full or non-receiving page");
`endif

endmodule

// File: rtl/flash_eeprom_emulator.sv
// Two-page flash record store, top level: fee_ctrl sequencer and fee_dp datapath.
// Depends on fee_pkg, fee_ctrl and fee_dp.
//
// Usage: one command per input transfer (in_command: initialize, read, write),
// one result transfer (out_status, out_read_data) per command. Both channels
// use valid/stall; an item moves when valid is high and stall is low.
// Initialize or an early error goes from dispatch to the output register;
// a read scans back from the newest slot (up to 204), reading each slot and
// checking its tag; a plain write stores the record at dispatch. A write that
// finds the page full compacts it: each source slot is read, and each live tag
// is checked against the dedup table entry by entry before it is copied.
// One item is worked on at a time; the next is taken as soon as the result
// sits in the output register, even while the receiver stalls it. A finished
// result waits for the output register to free before it is loaded.
// Reset: both pages erased, fill counts zero; no clearing pass is needed.
module flash_eeprom_emulator
  import fee_pkg::*;
#(
  parameter int PAGE_BYTES    = 2048,
  parameter int RECORD_BYTES  = 8,
  parameter int DEDUP_ENTRIES = 68
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_virtual_address,
  input  logic [63:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_read_data
);

  fee_cmd_t  cmd;
  fee_stat_t st;

  fee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  fee_dp #(
    .PAGE_BYTES    (PAGE_BYTES),
    .RECORD_BYTES  (RECORD_BYTES),
    .DEDUP_ENTRIES (DEDUP_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_virtual_address (in_virtual_address),
    .in_write_data      (in_write_data),
    .out_status         (out_status),
    .out_read_data      (out_read_data),
    .cmd                (cmd),
    .st                 (st)
  );

endmodule
